/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pbps_pkg.sv */
package pbps_pkg;

   localparam int DEF_MAX_POINTS = 256;
   localparam int DEF_COORD_BITS = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 2'd2;

   localparam logic [1:0]  ORDER_RST = 2'd3;
   localparam logic [8:0]  COUNT_RST = 9'd4;
   localparam logic [23:0] SPEED_RST = 24'd65536;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [16:0] Q16_ONE = 17'h10000;

   // ceil(2^20 / 3), exact quotient for values below 2^19
   localparam logic [18:0] RECIP3 = 19'd349526;

   typedef struct packed {
      logic       cap;
      logic [1:0] cap_idx;
      logic       sub;
      logic       mul;
      logic       add;
      logic [1:0] idx;
   } lane_ctl_type;

   function automatic logic [1:0] mod3_9(input logic [8:0] v);
      logic [3:0] s1;
      logic [2:0] s2;
      s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[8]);
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
      if (s2 >= 3'd6) begin
         return 2'(s2 - 3'd6);
      end else if (s2 >= 3'd3) begin
         return 2'(s2 - 3'd3);
      end else begin
         return s2[1:0];
      end
   endfunction

endpackage

/* rtl/pbps_ram.sv */
module pbps_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pbps_lane.sv */
module pbps_lane #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  pbps_pkg::lane_ctl_type       ctl,
   input  logic signed [COORD_BITS-1:0] cap_data,
   input  logic [16:0]                  frac,
   output logic signed [COORD_BITS-1:0] point
);
   import pbps_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = COORD_BITS + 19;

   logic signed [COORD_BITS-1:0] pt_ff [4];
   logic signed [COORD_BITS-1:0] pt_in [4];
   logic signed [DW-1:0]         diff_ff;
   logic signed [DW-1:0]         diff_in;
   logic signed [PW-1:0]         prod_ff;
   logic signed [PW-1:0]         prod_in;
   logic signed [DW-1:0]         step;
   logic signed [DW-1:0]         sum;
   logic [1:0]                   idx_nx;

   assign idx_nx = 2'(ctl.idx + 2'd1);
   // floor(d * t / 2^16) stays within d
   assign step   = signed'(prod_ff[COORD_BITS+16:16]);
   assign sum    = DW'(pt_ff[ctl.idx]) + step;

   always_comb begin
      pt_in   = pt_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      if (ctl.cap) begin
         pt_in[ctl.cap_idx] = cap_data;
      end else if (ctl.add) begin
         pt_in[ctl.idx] = COORD_BITS'(sum);
      end
      if (ctl.sub) begin
         diff_in = DW'(pt_ff[idx_nx]) - DW'(pt_ff[ctl.idx]);
      end
      if (ctl.mul) begin
         prod_in = PW'(diff_ff) * PW'(signed'({1'b0, frac}));
      end
   end

   always_ff @(posedge clock) begin
      pt_ff   <= pt_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   assign point = pt_ff[0];

endmodule

/* rtl/piecewise_bezier_path_stepper_top.sv */
// Piecewise Bezier path stepper. Load requests (op 0) write one signed Q16.16
// control point into the point table and leave the intake open. A tick
// request (op 1) advances the Q1.16 progress by travel_speed * elapsed_time /
// curve_order (capped at 1.0), steps the segment start by curve_order when
// progress passes 1.0, then evaluates the segment by de Casteljau
// interpolation and returns one response. Each axis has its own interpolator
// built from one subtractor and one multiplier, reused for every interpolation
// under a small sequencer; a tick stalls the intake from its acceptance until
// its response is issued. The point table is a single-read memory, fetched one
// point per cycle. Reading a table slot that was never loaded gives undefined
// positions. Registers are to be written through the csr port only while no
// tick is in flight; the user must keep to this, the block does not enforce it.
module piecewise_bezier_path_stepper_top #(
   parameter int MAX_POINTS = pbps_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS = pbps_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [7:0]                        req_point_index,
   input  logic signed [31:0]                req_load_x,
   input  logic signed [31:0]                req_load_y,
   input  logic signed [31:0]                req_load_z,
   input  logic [15:0]                       req_elapsed_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_pos_x,
   output logic signed [31:0]                rsp_pos_y,
   output logic signed [31:0]                rsp_pos_z,
   output logic [7:0]                        rsp_segment_start,
   output logic [16:0]                       rsp_fraction,
   input  logic                              csr_wr_en,
   input  logic [pbps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbps_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import pbps_pkg::*;

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int SW    = ((AW > 8) ? AW : 8) + 1;
   localparam int MP_W  = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (MP_W > 9) ? MP_W : 9;
   localparam int CB    = COORD_BITS;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INC_MUL   = 4'd1;
   localparam logic [3:0] S_INC_DIV   = 4'd2;
   localparam logic [3:0] S_ADVANCE   = 4'd3;
   localparam logic [3:0] S_READ      = 4'd4;
   localparam logic [3:0] S_READ_LAST = 4'd5;
   localparam logic [3:0] S_SUB       = 4'd6;
   localparam logic [3:0] S_MUL       = 4'd7;
   localparam logic [3:0] S_ADD       = 4'd8;
   localparam logic [3:0] S_DONE      = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  order_ff;
   logic [8:0]  count_ff;
   logic [23:0] speed_ff;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [39:0] mul_ff, mul_in;
   logic [16:0] inc_ff, inc_in;
   logic [16:0] progress_ff, progress_in;
   logic [7:0]  base_ff, base_in;
   logic [1:0]  rd_cnt_ff, rd_cnt_in;
   logic [1:0]  lvl_ff, lvl_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [7:0]  seg_ff;
   logic [16:0] frac_ff;

   logic              req_acc;
   logic              rsp_free;
   logic [1:0]        order;
   logic [8:0]        count_c;
   logic [8:0]        count_m1;
   logic [1:0]        count_rem;
   logic [8:0]        limit;
   logic [9:0]        base_next;
   logic              wrap;
   logic [17:0]       acc_sum;
   logic [23:0]       q;
   logic [36:0]       div_prod;
   logic [16:0]       inc_val;
   logic [SW-1:0]     addr_sum;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     slot_tab [256];
   logic [3*CB-1:0]   wr_data;
   logic [3*CB-1:0]   rd_data;
   lane_ctl_type      lane_ctl;
   logic signed [CB-1:0] lane_pt [3];

   assign req_acc  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RST;
         count_ff <= COUNT_RST;
         speed_ff <= SPEED_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ORDER: order_ff <= csr_wr_data[1:0];
            CSR_COUNT: count_ff <= csr_wr_data[8:0];
            CSR_SPEED: speed_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // order zero acts as linear
   assign order = (order_ff == 2'd0) ? 2'd1 : order_ff;

   always_comb begin
      if (count_ff < 9'd2) begin
         count_c = 9'd2;
      end else if (CMP_W'(count_ff) > CMP_W'(MAX_POINTS)) begin
         count_c = 9'(MAX_POINTS);
      end else begin
         count_c = count_ff;
      end
   end

   assign count_m1 = count_c - 9'd1;

   always_comb begin
      priority if (order == 2'd1) begin
         count_rem = 2'd0;
      end else if (order == 2'd2) begin
         count_rem = {1'b0, count_m1[0]};
      end else begin
         count_rem = mod3_9(count_m1);
      end
   end

   assign limit     = count_m1 - 9'(count_rem);
   assign base_next = 10'(base_ff) + 10'(order);
   assign wrap      = (base_next >= 10'(limit));
   assign acc_sum   = 18'(progress_ff) + 18'(inc_ff);

   // increment = floor(speed * elapsed / (order * 2^16)), capped at one
   assign q        = mul_ff[39:16];
   assign div_prod = 37'(q[17:0]) * 37'(RECIP3);

   always_comb begin
      if (q >= 24'({order, 16'h0000})) begin
         inc_val = Q16_ONE;
      end else if (order == 2'd1) begin
         inc_val = q[16:0];
      end else if (order == 2'd2) begin
         inc_val = q[17:1];
      end else begin
         inc_val = div_prod[36:20];
      end
   end

   // table slot wraps at the table depth
   for (genvar gi = 0; gi < 256; gi++) begin : g_slot
      assign slot_tab[gi] = AW'(gi % MAX_POINTS);
   end

   always_comb begin
      addr_sum = SW'(base_ff) + SW'(rd_cnt_ff);
      if (addr_sum >= SW'(MAX_POINTS)) begin
         addr_sum = addr_sum - SW'(MAX_POINTS);
      end
   end

   assign rd_addr = addr_sum[AW-1:0];
   assign wr_data = {CB'(req_load_z), CB'(req_load_y), CB'(req_load_x)};

   pbps_ram #(
      .WIDTH (3 * CB),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_acc && (req_op == OP_LOAD)),
      .wr_addr (slot_tab[req_point_index]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      pbps_lane #(
         .COORD_BITS (CB)
      ) u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .cap_data (signed'(rd_data[gl*CB +: CB])),
         .frac     (progress_ff),
         .point    (lane_pt[gl])
      );
   end

   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      mul_in       = mul_ff;
      inc_in       = inc_ff;
      progress_in  = progress_ff;
      base_in      = base_ff;
      rd_cnt_in    = rd_cnt_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lane_ctl     = '0;
      lane_ctl.idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_op == OP_TICK)) begin
               elapsed_in = req_elapsed_time;
               state_in   = S_INC_MUL;
            end
         end
         S_INC_MUL: begin
            mul_in   = 40'(speed_ff) * 40'(elapsed_ff);
            state_in = S_INC_DIV;
         end
         S_INC_DIV: begin
            inc_in   = inc_val;
            state_in = S_ADVANCE;
         end
         S_ADVANCE: begin
            if (acc_sum > 18'(Q16_ONE)) begin
               progress_in = 17'(acc_sum - 18'(Q16_ONE));
               base_in     = wrap ? 8'd0 : base_next[7:0];
            end else begin
               progress_in = acc_sum[16:0];
            end
            rd_cnt_in = 2'd0;
            state_in  = S_READ;
         end
         S_READ: begin
            lane_ctl.cap     = (rd_cnt_ff != 2'd0);
            lane_ctl.cap_idx = 2'(rd_cnt_ff - 2'd1);
            if (rd_cnt_ff == order) begin
               state_in = S_READ_LAST;
            end else begin
               rd_cnt_in = 2'(rd_cnt_ff + 2'd1);
            end
         end
         S_READ_LAST: begin
            lane_ctl.cap     = 1'b1;
            lane_ctl.cap_idx = rd_cnt_ff;
            lvl_in           = order;
            idx_in           = 2'd0;
            state_in         = S_SUB;
         end
         S_SUB: begin
            lane_ctl.sub = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            lane_ctl.mul = 1'b1;
            state_in     = S_ADD;
         end
         S_ADD: begin
            lane_ctl.add = 1'b1;
            if (idx_ff == 2'(lvl_ff - 2'd1)) begin
               if (lvl_ff == 2'd1) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in   = 2'(lvl_ff - 2'd1);
                  idx_in   = 2'd0;
                  state_in = S_SUB;
               end
            end else begin
               idx_in   = 2'(idx_ff + 2'd1);
               state_in = S_SUB;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         progress_ff  <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         progress_ff  <= progress_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      mul_ff     <= mul_in;
      inc_ff     <= inc_in;
      rd_cnt_ff  <= rd_cnt_in;
      lvl_ff     <= lvl_in;
      idx_ff     <= idx_in;
      if ((state_ff == S_DONE) && rsp_free) begin
         pos_x_ff <= 32'(lane_pt[0]);
         pos_y_ff <= 32'(lane_pt[1]);
         pos_z_ff <= 32'(lane_pt[2]);
         seg_ff   <= base_ff;
         frac_ff  <= progress_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_pos_z         = pos_z_ff;
   assign rsp_segment_start = seg_ff;
   assign rsp_fraction      = frac_ff;

endmodule

/* rtl/pbps_checker.sv */
`include "assert_macros.svh"

module pbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pos_x,
   input logic [16:0] rsp_fraction
);

   // a tick keeps the intake closed while it is evaluated
   `CHK_NEXT(a_tick_busy, clock, reset, req_valid && !req_stall && req_op, req_stall, "tick did not block intake")

   // a load leaves the intake open
   `CHK_NEXT(a_load_free, clock, reset, req_valid && !req_stall && !req_op, !req_stall, "load blocked intake")

   `CHK_IMPLY(a_frac_range, clock, reset, rsp_valid, rsp_fraction <= 17'h10000, "fraction above one")

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_fraction), "stalled response changed")

endmodule

bind piecewise_bezier_path_stepper_top pbps_checker u_pbps_checker (.*);
